>>> rtl/lprc_pkg.sv
`default_nettype none

package lprc_pkg;

   // Record format limits
   localparam int MaxHeader  = 256;
   localparam int LenBits    = 32;
   localparam int HdrCntBits = 9;
   localparam int RemBits    = LenBits + 1;
   localparam int ChunkBits  = 34;

   localparam logic [7:0]  ColonChar      = 8'h3A;
   localparam logic [7:0]  DigitZero      = 8'h30;
   localparam logic [7:0]  DigitNine      = 8'h39;
   localparam logic [31:0] ThresholdReset = 32'd131072;

   // Register map (byte address bit 2 selects the register)
   localparam logic REG_CHUNKING_ENABLE = 1'b0;
   localparam logic REG_CHUNK_THRESHOLD = 1'b1;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
   localparam logic [2:0] ERR_EMPTY_LEN = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;
   localparam logic [2:0] ERR_HALTED    = 3'd6;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DONE    = 2'd2,
      PH_HALT    = 2'd3
   } phase_type;

   typedef struct packed {
      logic        chunking_enable;
      logic [31:0] chunk_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_header;
      logic       record_last;
      logic       chunk_last;
      logic [2:0] error_code;
      logic       stream_done;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/lprc_csr.sv
`default_nettype none

module lprc_csr
   import lprc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   logic        enable_ff;
   logic        enable_in;
   logic [31:0] threshold_ff;
   logic [31:0] threshold_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      enable_in    = enable_ff;
      threshold_in = threshold_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_CHUNKING_ENABLE: enable_in    = pwdata[0];
            REG_CHUNK_THRESHOLD: threshold_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         threshold_ff <= ThresholdReset;
      end else begin
         enable_ff    <= enable_in;
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_CHUNKING_ENABLE: prdata = {31'd0, enable_ff};
         REG_CHUNK_THRESHOLD: prdata = threshold_ff;
         default:             prdata = 32'd0;
      endcase
   end

   assign cfg.chunking_enable = enable_ff;
   assign cfg.chunk_threshold = threshold_ff;

endmodule

`default_nettype wire

>>> rtl/lprc_core.sv
`default_nettype none

module lprc_core
   import lprc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic [7:0] in_byte,
   input  wire logic       end_of_stream,
   input  wire cfg_type    cfg,
   output result_type      result
);

   phase_type              phase_ff, phase_in;
   logic [HdrCntBits-1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [LenBits-1:0]     len_ff, len_in;
   logic [RemBits-1:0]     rem_ff, rem_in;
   logic [ChunkBits-1:0]   chunk_ff, chunk_in;

   logic [HdrCntBits:0]    hdr_cnt_next;
   logic [LenBits+3:0]     len_times_ten;
   logic [RemBits-1:0]     rem_dec;
   logic [ChunkBits-1:0]   chunk_inc;
   logic                   is_digit;
   logic                   is_colon;
   logic                   close_chunk;

   assign hdr_cnt_next = {1'b0, hdr_cnt_ff} + 1'b1;
   assign is_colon     = (in_byte == ColonChar);
   assign is_digit     = (in_byte >= DigitZero) && (in_byte <= DigitNine);

   // Length times ten plus the new digit, kept wide so an overflow shows in the top bits.
   assign len_times_ten = ({4'd0, len_ff} << 3) + ({4'd0, len_ff} << 1)
                          + {{(LenBits){1'b0}}, in_byte[3:0]};

   assign rem_dec   = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
   assign chunk_inc = (chunk_ff != '1) ? chunk_ff + 1'b1 : chunk_ff;
   assign close_chunk = !cfg.chunking_enable
                        || (chunk_inc >= {{(ChunkBits-32){1'b0}}, cfg.chunk_threshold});

   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      chunk_in   = chunk_ff;
      result     = '0;

      case (phase_ff)
         PH_HALT: begin
            result.error_code  = ERR_HALTED;
            result.stream_done = 1'b1;
         end
         PH_DONE: begin
            result.stream_done = 1'b1;
         end
         PH_HEADER, PH_PAYLOAD: begin
            if (end_of_stream) begin
               phase_in           = PH_DONE;
               chunk_in           = '0;
               result.stream_done = 1'b1;
               if (phase_ff == PH_HEADER && hdr_cnt_ff == '0) begin
                  result.chunk_last = (chunk_ff != '0);
                  result.error_code = ERR_NONE;
               end else begin
                  result.chunk_last = 1'b1;
                  result.error_code = ERR_TRUNCATED;
               end
            end else if (phase_ff == PH_HEADER) begin
               result.out_byte  = in_byte;
               result.in_header = 1'b1;
               if (is_colon) begin
                  if (hdr_cnt_ff == '0) begin
                     phase_in           = PH_HALT;
                     result.error_code  = ERR_EMPTY_LEN;
                     result.stream_done = 1'b1;
                  end else begin
                     phase_in   = PH_PAYLOAD;
                     hdr_cnt_in = hdr_cnt_next[HdrCntBits-1:0];
                     rem_in     = {1'b0, len_ff} + 1'b1;
                     chunk_in   = chunk_inc;
                  end
               end else if (!is_digit) begin
                  phase_in           = PH_HALT;
                  result.error_code  = ERR_BAD_CHAR;
                  result.stream_done = 1'b1;
               end else if (hdr_cnt_next >= (HdrCntBits+1)'(MaxHeader)) begin
                  phase_in           = PH_HALT;
                  result.error_code  = ERR_TOO_LONG;
                  result.stream_done = 1'b1;
               end else if (len_times_ten[LenBits+3:LenBits] != 4'd0) begin
                  phase_in           = PH_HALT;
                  result.error_code  = ERR_OVERFLOW;
                  result.stream_done = 1'b1;
               end else begin
                  len_in     = len_times_ten[LenBits-1:0];
                  hdr_cnt_in = hdr_cnt_next[HdrCntBits-1:0];
                  chunk_in   = chunk_inc;
               end
            end else begin
               result.out_byte = in_byte;
               rem_in          = rem_dec;
               chunk_in        = chunk_inc;
               if (rem_dec == '0) begin
                  result.record_last = 1'b1;
                  result.chunk_last  = close_chunk;
                  if (close_chunk) begin
                     chunk_in = '0;
                  end
                  phase_in   = PH_HEADER;
                  hdr_cnt_in = '0;
                  len_in     = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
         len_ff     <= '0;
         rem_ff     <= '0;
         chunk_ff   <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         len_ff     <= len_in;
         rem_ff     <= rem_in;
         chunk_ff   <= chunk_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/lprc_out.sv
`default_nettype none

module lprc_out
   import lprc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   input  wire logic       rsp_stall,
   output logic            busy,
   output logic            rsp_valid,
   output result_type      rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // The held result only blocks a new request while the receiver is stalling.
   assign busy     = valid_ff & rsp_stall;
   assign valid_in = load | busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

>>> rtl/length_prefixed_record_chunker.sv
// Length-prefixed record chunker.
// Requests arrive on the req_ channel, one byte (or an end-of-stream mark) per
// request, and are accepted at a clock edge where req_valid is high and
// req_stall is low. Each accepted request gives exactly one result on the rsp_
// channel: the byte, its header/payload marks, the record and chunk boundary
// marks, an error code and a stream-done flag.
// The result is registered: it is valid in the cycle after acceptance.
// Throughput is one request per cycle unless the receiver stalls; the per-byte
// work is a few counters and a length multiply-by-ten done by shifts, all ahead
// of the result register. When the receiver stalls, the result register holds
// its value and req_stall is raised, so no further request is taken until the
// result has gone. A header error halts the block until reset; end of stream
// moves it to a done state. Either way every later request still gets a result.
// The two configuration registers sit on the APB port at byte addresses 0
// (chunking enable) and 4 (chunk threshold) and should be written while idle.
// Synchronous reset clears the record state and restores the register defaults.
`default_nettype none

module length_prefixed_record_chunker
   import lprc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_in_header,
   output logic             rsp_record_last,
   output logic             rsp_chunk_last,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_stream_done,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type    cfg;
   result_type step_result;
   result_type held_result;
   logic       accept;
   logic       busy;

   assign req_stall = busy;
   assign accept    = req_valid & ~busy;

   lprc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lprc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .in_byte       (req_in_byte),
      .end_of_stream (req_end_of_stream),
      .cfg           (cfg),
      .result        (step_result)
   );

   lprc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (step_result),
      .rsp_stall  (rsp_stall),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_result (held_result)
   );

   assign rsp_out_byte    = held_result.out_byte;
   assign rsp_in_header   = held_result.in_header;
   assign rsp_record_last = held_result.record_last;
   assign rsp_chunk_last  = held_result.chunk_last;
   assign rsp_error_code  = held_result.error_code;
   assign rsp_stream_done = held_result.stream_done;

endmodule

`default_nettype wire
